// ===== hdl/rdbpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rdbpwm_pkg
// Shared types and constants of the ramped-duty bridge pwm generator.
// ----------------------------------------------------------------------------
package rdbpwm_pkg;

  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;
  localparam int PreW    = 16;
  localparam int TopW    = 16;
  localparam int StepsW  = 7;
  localparam int DutyW   = 17;

  typedef logic [CfgW-1:0]    cfg_data_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [DutyW-1:0]   duty_t;

  // register indexes of the configuration port
  localparam cfg_idx_t REG_PRESCALE = 2'd0;
  localparam cfg_idx_t REG_TOP      = 2'd1;
  localparam cfg_idx_t REG_STEPS    = 2'd2;

  localparam logic [PreW-1:0]   PRESCALE_RST = 16'd0;
  localparam logic [TopW-1:0]   TOP_RST      = 16'd1000;
  localparam logic [StepsW-1:0] STEPS_RST    = 7'd8;

endpackage

// ===== hdl/rdbpwm_in_if.sv =====
// ----------------------------------------------------------------------------
// rdbpwm_in_if
// Input channel: one timer clock tick enable per word.
// ----------------------------------------------------------------------------
interface rdbpwm_in_if;
  logic valid;
  logic ready;
  logic clock_enable;

  modport source (output valid, output clock_enable, input ready);
  modport sink (input valid, input clock_enable, output ready);
endinterface

// ===== hdl/rdbpwm_out_if.sv =====
// ----------------------------------------------------------------------------
// rdbpwm_out_if
// Result channel: bridge drive levels and duty status per word.
// ----------------------------------------------------------------------------
interface rdbpwm_out_if;
  import rdbpwm_pkg::*;

  logic  valid;
  logic  ready;
  logic  first_channel_out;
  logic  second_channel_out;
  logic  period_end;
  duty_t duty_now;
  logic  half_select;

  modport source (
    output valid, output first_channel_out, output second_channel_out,
    output period_end, output duty_now, output half_select, input ready
  );
  modport sink (
    input valid, input first_channel_out, input second_channel_out,
    input period_end, input duty_now, input half_select, output ready
  );
endinterface

// ===== hdl/ramped_duty_bridge_pwm_generator.sv =====
// ----------------------------------------------------------------------------
// ramped_duty_bridge_pwm_generator
// Prescaled up-counter pwm for a single-phase bridge with a ramped duty.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | contents
//  in_ch   | in  | valid/ready       | clock_enable
//  out_ch  | out | valid/ready       | channel levels, period_end, duty_now,
//          |     |                   | half_select
//  cfg_*   | in  | cfg_we, no wait   | prescale, period_top, steps_per_half
//
// one word per cycle while the divider is idle and the result register is
// free or being taken: the counter and duty sequencer update in a single pass
// into the result register. after any configuration write the step size is
// recomputed by a bit-serial divider; in_ch.ready stays low while it runs.
// reset is synchronous (rst_n low); the configuration returns to its defaults.
// ----------------------------------------------------------------------------
module ramped_duty_bridge_pwm_generator #(
  parameter int COUNT_BITS     = 16,
  parameter int HALF_END_LIMIT = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  rdbpwm_pkg::cfg_idx_t  cfg_index,
  input  rdbpwm_pkg::cfg_data_t cfg_wdata,
  rdbpwm_in_if.sink             in_ch,
  rdbpwm_out_if.source          out_ch
);
  import rdbpwm_pkg::*;

  localparam int CmpW = (COUNT_BITS > DutyW) ? COUNT_BITS : DutyW;
  localparam logic [TopW-1:0] TopMask =
    (COUNT_BITS >= TopW) ? {TopW{1'b1}} : TopW'((64'd1 << COUNT_BITS) - 64'd1);
  // step size for the reset configuration, with the counter width applied
  localparam logic [TopW-1:0] StepRst = (TOP_RST & TopMask) / TopW'(STEPS_RST);
  localparam duty_t HalfLimit = DutyW'(HALF_END_LIMIT);
  localparam logic [4:0] DivLoad = 5'd17;

  // configuration
  logic [PreW-1:0]   prescale_r;
  logic [TopW-1:0]   period_top_r;
  logic [StepsW-1:0] steps_r;

  // step size divider
  logic [4:0]      div_cnt_r;
  logic [7:0]      div_rem_r, div_rem_nxt;
  logic [TopW-1:0] div_quo_r, div_quo_nxt;
  logic [TopW-1:0] step_r;
  logic [7:0]      rem_sh, divisor;
  logic            div_ge, div_busy;

  // timer state
  logic [PreW-1:0]       pre_cnt_r, pre_cnt_nxt;
  logic [COUNT_BITS-1:0] per_cnt_r, per_cnt_nxt;
  duty_t                 cmp_r, cmp_nxt;
  duty_t                 duty_r, duty_nxt;
  logic                  ramp_down_r, ramp_down_nxt;
  logic                  half_r, half_nxt;
  logic                  wrap;

  // result register
  logic  out_valid_r;
  logic  out_first_r, out_second_r, out_pend_r, out_half_r;
  duty_t out_duty_r;
  logic  active;

  logic      in_acc;
  logic [TopW-1:0] top_eff;
  duty_t     top17, step17, duty_a, duty_sub;
  logic      rd_a;

  assign top_eff  = period_top_r & TopMask;
  assign top17    = DutyW'(top_eff);
  assign step17   = DutyW'(step_r);
  assign div_busy = (div_cnt_r != 5'd0);

  assign in_ch.ready = !div_busy && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // restoring division, one quotient bit a cycle; zero steps count as one
  assign divisor = (steps_r == '0) ? 8'd1 : {1'b0, steps_r};
  assign rem_sh  = {div_rem_r[6:0], div_quo_r[TopW-1]};
  assign div_ge  = (rem_sh >= divisor);

  always_comb begin
    div_rem_nxt = div_ge ? (rem_sh - divisor) : rem_sh;
    div_quo_nxt = {div_quo_r[TopW-2:0], div_ge};
  end

  // counter and duty sequencer
  always_comb begin
    pre_cnt_nxt   = pre_cnt_r;
    per_cnt_nxt   = per_cnt_r;
    cmp_nxt       = cmp_r;
    duty_nxt      = duty_r;
    ramp_down_nxt = ramp_down_r;
    half_nxt      = half_r;
    wrap          = 1'b0;
    duty_a        = duty_r;
    rd_a          = ramp_down_r;
    duty_sub      = '0;

    if (in_ch.clock_enable) begin
      if (pre_cnt_r >= prescale_r) begin
        pre_cnt_nxt = '0;
        if (CmpW'(per_cnt_r) >= CmpW'(top_eff)) begin
          per_cnt_nxt = '0;
          wrap        = 1'b1;
        end else begin
          per_cnt_nxt = per_cnt_r + 1'b1;
        end
      end else begin
        pre_cnt_nxt = pre_cnt_r + 1'b1;
      end
    end

    if (wrap) begin
      // peak passed: turn the ramp round; low limit reached: swap half-wave
      if (duty_r > top17) begin
        rd_a   = 1'b1;
        duty_a = top17 + step17;
      end else if (duty_r < HalfLimit) begin
        rd_a     = 1'b0;
        half_nxt = !half_r;
        duty_a   = step17;
      end
      ramp_down_nxt = rd_a;
      if (!rd_a) begin
        cmp_nxt  = duty_a;
        duty_nxt = duty_a + step17;
      end else begin
        duty_sub = (duty_a >= step17) ? (duty_a - step17) : '0;
        cmp_nxt  = duty_sub;
        duty_nxt = (duty_sub == step17) ? '0 : duty_sub;
      end
    end
  end

  assign active = (CmpW'(per_cnt_nxt) < CmpW'(cmp_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r   <= PRESCALE_RST;
      period_top_r <= TOP_RST;
      steps_r      <= STEPS_RST;
      div_cnt_r    <= '0;
      step_r       <= StepRst;
      pre_cnt_r    <= '0;
      per_cnt_r    <= '0;
      cmp_r        <= DutyW'(StepRst);
      duty_r       <= DutyW'(StepRst);
      ramp_down_r  <= 1'b0;
      half_r       <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PRESCALE: prescale_r   <= cfg_wdata;
          REG_TOP:      period_top_r <= cfg_wdata;
          REG_STEPS:    steps_r      <= cfg_wdata[StepsW-1:0];
          default:      ;
        endcase
      end

      if (cfg_we) begin
        div_cnt_r <= DivLoad;
      end else if (div_cnt_r == DivLoad) begin
        div_cnt_r <= div_cnt_r - 5'd1;
        div_rem_r <= '0;
        div_quo_r <= top_eff;
      end else if (div_busy) begin
        div_cnt_r <= div_cnt_r - 5'd1;
        div_rem_r <= div_rem_nxt;
        div_quo_r <= div_quo_nxt;
        if (div_cnt_r == 5'd1) begin
          step_r <= div_quo_nxt;
        end
      end

      if (in_acc) begin
        pre_cnt_r   <= pre_cnt_nxt;
        per_cnt_r   <= per_cnt_nxt;
        cmp_r       <= cmp_nxt;
        duty_r      <= duty_nxt;
        ramp_down_r <= ramp_down_nxt;
        half_r      <= half_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_acc) begin
      out_first_r  <= active && !half_nxt;
      out_second_r <= active && half_nxt;
      out_pend_r   <= wrap;
      out_duty_r   <= cmp_nxt;
      out_half_r   <= half_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.first_channel_out  = out_first_r;
  assign out_ch.second_channel_out = out_second_r;
  assign out_ch.period_end         = out_pend_r;
  assign out_ch.duty_now           = out_duty_r;
  assign out_ch.half_select        = out_half_r;

`ifndef NO_ASSERTIONS
  // no word may enter while the step size is being recomputed
  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> !in_ch.ready)
    else $error("input accepted during step size division");

  // a held clock never produces a period end
  a_hold_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.clock_enable) |=> !out_pend_r)
    else $error("period end on a held clock word");

  // a half-wave swap always restarts the ramp going up
  a_swap_ramps_up: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (half_nxt != half_r)) |=> !ramp_down_r)
    else $error("half-wave swap left the ramp going down");

  // both channels are never driven together
  a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_first_r && out_second_r))
    else $error("both bridge channels driven");
`endif

endmodule

// ===== tb/ramped_duty_bridge_pwm_generator_test.sv =====
// ----------------------------------------------------------------------------
// ramped_duty_bridge_pwm_generator_test
// Self-checking bench for the ramped-duty bridge pwm generator. Tick words
// are sent with random gaps and predicted by a cycle-exact duty sequencer
// kept here; every result word is compared field by field, in order.
// ----------------------------------------------------------------------------
module ramped_duty_bridge_pwm_generator_test;
  import rdbpwm_pkg::*;

  localparam int CountBits    = 16;
  localparam int HalfEndLimit = 100;
  localparam int RandomItems  = 1000;
  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 20;
  localparam int HoldCycles   = 400;
  localparam cfg_idx_t RegUnused = 2'd3;

  typedef struct packed {
    logic  ch1;
    logic  ch2;
    logic  wrap;
    duty_t duty;
    logic  half;
  } pwm_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  rdbpwm_in_if  in_ch ();
  rdbpwm_out_if out_ch ();

  ramped_duty_bridge_pwm_generator #(
    .COUNT_BITS     (CountBits),
    .HALF_END_LIMIT (HalfEndLimit)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor copy of configuration and sequencer state
  logic [PreW-1:0]   cfg_pre;
  logic [TopW-1:0]   cfg_top;
  logic [StepsW-1:0] cfg_steps;
  logic [PreW-1:0]   pre_cnt;
  logic [TopW-1:0]   per_cnt;
  duty_t             cmp;
  duty_t             nxt;
  bit                going_down;
  bit                half;

  pwm_word_t expected_words[$];
  int  fail_count = 0;
  int  n_ticks    = 0;
  int  n_checked  = 0;
  int  n_wraps    = 0;
  int  n_flips    = 0;
  int  n_writes   = 0;
  int  hold_len   = 0;
  bit  tx_idle    = 1'b1;
  bit  rx_idle    = 1'b1;
  bit  last_half  = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned duty_step();
    int unsigned n;
    n = (cfg_steps == '0) ? 1 : cfg_steps;
    return cfg_top / n;
  endfunction

  function automatic void advance_ramp();
    int unsigned top;
    int unsigned stp;
    top = cfg_top;
    stp = duty_step();
    if (nxt > top) begin
      going_down = 1'b1;
      nxt = duty_t'(top + stp);
    end else if (nxt < HalfEndLimit) begin
      going_down = 1'b0;
      half = ~half;
      nxt = duty_t'(stp);
    end
    if (!going_down) begin
      cmp = nxt;
      nxt = duty_t'(nxt + stp);
    end else begin
      // ramp-down saturates at zero
      nxt = (nxt >= stp) ? duty_t'(nxt - stp) : '0;
      cmp = nxt;
      if (nxt == stp) nxt = '0;
    end
  endfunction

  function automatic pwm_word_t predict_tick(input bit en);
    pwm_word_t w;
    bit on;
    w.wrap = 1'b0;
    if (en) begin
      if (pre_cnt >= cfg_pre) begin
        pre_cnt = '0;
        if (per_cnt >= cfg_top) begin
          per_cnt = '0;
          w.wrap = 1'b1;
          advance_ramp();
        end else begin
          per_cnt = per_cnt + 1'b1;
        end
      end else begin
        pre_cnt = pre_cnt + 1'b1;
      end
    end
    on = (per_cnt < cmp);
    w.ch1  = !half && on;
    w.ch2  = half && on;
    w.duty = cmp;
    w.half = half;
    return w;
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input cfg_data_t data);
    case (idx)
      REG_PRESCALE: cfg_pre = data;
      REG_TOP:      cfg_top = data;
      REG_STEPS:    cfg_steps = data[StepsW-1:0];
      default: ;
    endcase
  endfunction

  // result check first, then prediction of the word accepted at this edge
  always @(posedge clk) begin : scoreboard
    pwm_word_t want;
    pwm_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.first_channel_out, out_ch.second_channel_out,
              out_ch.period_end, out_ch.duty_now, out_ch.half_select};
      if (expected_words.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        n_checked++;
        if (got.ch1 !== want.ch1) begin
          $error("first_channel_out: expected %0d, got %0d", want.ch1, got.ch1);
          fail_count++;
        end
        if (got.ch2 !== want.ch2) begin
          $error("second_channel_out: expected %0d, got %0d", want.ch2, got.ch2);
          fail_count++;
        end
        if (got.wrap !== want.wrap) begin
          $error("period_end: expected %0d, got %0d", want.wrap, got.wrap);
          fail_count++;
        end
        if (got.duty !== want.duty) begin
          $error("duty_now: expected %0d, got %0d", want.duty, got.duty);
          fail_count++;
        end
        if (got.half !== want.half) begin
          $error("half_select: expected %0d, got %0d", want.half, got.half);
          fail_count++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      want = predict_tick(in_ch.clock_enable);
      expected_words.push_back(want);
      n_ticks++;
      if (want.wrap) n_wraps++;
      if (want.half != last_half) n_flips++;
      last_half = want.half;
    end
  end

  // result side: random gaps, or one long hold-off on request
  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        gap = hold_len;
        hold_len = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 17) : 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // valid stays high between back-to-back words
  task automatic send_tick(input bit en);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.clock_enable <= en;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
    n_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();
  endtask

  // prescaler count above a newly lowered prescale wraps on the next step
  task automatic test_prescale_lowered();
    write_reg(REG_PRESCALE, 16'd3);
    repeat (3) send_tick(1'b1);
    settle();
    write_reg(REG_PRESCALE, 16'd1);
    repeat (2) send_tick(1'b1);
    settle();
  endtask

  task automatic test_top_lowered();
    write_reg(REG_PRESCALE, 16'd0);
    write_reg(REG_TOP, 16'hFFFF);
    write_reg(REG_STEPS, 16'd127);
    repeat (4) send_tick(1'b1);
    settle();
    write_reg(REG_TOP, 16'd2);
    repeat (3) send_tick(1'b1);
    settle();
  endtask

  // zero top wraps on every step, zero steps acts as one
  task automatic test_zero_settings();
    write_reg(REG_TOP, 16'd0);
    write_reg(REG_STEPS, 16'd0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
    write_reg(REG_STEPS, 16'hFFFF);
    write_reg(RegUnused, 16'hFFFF);
    write_reg(REG_PRESCALE, 16'hFFFF);
    repeat (3) send_tick(1'b1);
    settle();
  endtask

  task automatic test_random_ramps();
    int sent;
    int phase_len;
    sent = 0;
    while (sent < RandomItems) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_PRESCALE, 16'hFFFF);
          1:       write_reg(REG_PRESCALE, cfg_data_t'($urandom_range(0, 65535)));
          2, 3:    write_reg(REG_PRESCALE, 16'd1);
          default: write_reg(REG_PRESCALE, 16'd0);
        endcase
      end
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0:          write_reg(REG_TOP, 16'hFFFF);
          1:          write_reg(REG_TOP, cfg_data_t'($urandom_range(0, 65535)));
          2, 3, 4, 5: write_reg(REG_TOP, cfg_data_t'($urandom_range(0, 99)));
          default:    write_reg(REG_TOP, cfg_data_t'($urandom_range(100, 160)));
        endcase
      end
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_STEPS, cfg_data_t'($urandom_range(0, 65535)));
          1:       write_reg(REG_STEPS, cfg_data_t'($urandom_range(0, 127)));
          default: write_reg(REG_STEPS, cfg_data_t'($urandom_range(1, 6)));
        endcase
      end
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) send_tick($urandom_range(0, 9) != 0);
      sent += phase_len;
      settle();
    end
  endtask

  // long stall on the result side while words keep coming
  task automatic test_backpressure();
    write_reg(REG_PRESCALE, 16'd0);
    write_reg(REG_TOP, 16'd40);
    write_reg(REG_STEPS, 16'd3);
    tx_idle = 1'b0;
    hold_len = HoldCycles;
    repeat (80) send_tick(1'b1);
    settle();
    tx_idle = 1'b1;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_PRESCALE;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.clock_enable <= 1'b0;
    cfg_pre   = PRESCALE_RST;
    cfg_top   = TOP_RST;
    cfg_steps = STEPS_RST;
    pre_cnt   = '0;
    per_cnt   = '0;
    cmp       = duty_t'(duty_step());
    nxt       = cmp;
    going_down = 1'b0;
    half      = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_prescale_lowered();
    test_top_lowered();
    test_zero_settings();
    test_backpressure();
    test_random_ramps();

    settle();
    repeat (DrainCycles) @(posedge clk);
    $display("sent %0d tick words, checked %0d: %0d period ends, %0d half-wave changes",
             n_ticks, n_checked, n_wraps, n_flips);
    $display("%0d register writes incl. zero and full-scale settings, one long stall",
             n_writes);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
